// File: hw/rtl/hs_pkg.sv
package hs_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int PIX_W          = 16;
  localparam int NUM_W          = 2 * PIX_W;
  localparam int CNT_W          = $clog2(PIX_W);

  localparam logic [PIX_W-1:0] MAX_GRAY_RST = 16'd255;

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_APPLY   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_CHK  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

endpackage

// File: hw/rtl/histogram_stretch.sv
// Two-pass min/max contrast stretch of a gray image.
// Input stream s_axis: tdata = pixel, tuser = {first, func}. The host sends the
// image once with func = measure (first set on its first pixel) to collect the
// running min and max, then again with func = apply.
// Measure words produce nothing and leave tready high for the next word.
// Apply words give one output word on m_axis: tdata = stretched, tuser = flat.
// An apply word that reaches the divider passes through the 16x16 multiply,
// the overflow check and the one-bit-per-cycle restoring divider (a single
// shared unit), then loads the output register. tready stays low until that
// result is loaded, so no new word is accepted while an apply word is in
// flight. A flat range or a pixel at or below the min skips the divider, as
// does a quotient of 2^16 or more.
// The output register lets a new word in while a result still waits; a stalled
// receiver only blocks once the next apply result is ready to load.
// The user must write max_gray through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block does not enforce it. Reset (rst, synchronous)
// sets max_gray to 255, min to all ones, max to zero, and drops m_axis_tvalid.
module histogram_stretch #(
  parameter int PIXEL_BITS = hs_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // max_gray
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pixel
  input  logic [1:0]  s_axis_tuser,   // [0] func, [1] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] stretched
  output logic        m_axis_tuser    // [0] flat
);

  localparam int W = hs_pkg::PIX_W;
  localparam logic [W-1:0] PIX_MASK = W'((33'd1 << PIXEL_BITS) - 33'd1);

  hs_pkg::state_t state;

  logic [W-1:0]               max_gray;
  logic [W-1:0]               run_min;
  logic [W-1:0]               run_max;
  logic [W-1:0]               pix;
  logic [W-1:0]               range;
  logic [hs_pkg::NUM_W-1:0]   num;
  logic [W-1:0]               rem;
  logic [W-1:0]               quo;     // dividend low bits shift out, quotient in
  logic [hs_pkg::CNT_W-1:0]   cnt;
  logic                       flat;
  logic                       done;

  logic [W-1:0]               pix_in;
  logic [W-1:0]               base_min;
  logic [W-1:0]               base_max;
  logic [hs_pkg::NUM_W-1:0]   prod;
  logic [W:0]                 trial;
  logic                       in_acc;
  logic                       out_load;

  assign s_axis_tready = (state == hs_pkg::ST_IDLE) && !done;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pix_in        = s_axis_tdata & PIX_MASK;
  assign base_min      = s_axis_tuser[1] ? max_gray : run_min;
  assign base_max      = s_axis_tuser[1] ? '0 : run_max;
  assign prod          = {{W{1'b0}}, pix - run_min} * {{W{1'b0}}, max_gray};
  assign trial         = {rem, quo[W-1]} - {1'b0, range};
  assign out_load      = done && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gray <= hs_pkg::MAX_GRAY_RST;
    end else if (cfg_wr_en) begin
      max_gray <= cfg_wr_data;
    end
  end

  // running min/max, updated in the accept cycle of a measure word
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= '1;
      run_max <= '0;
    end else if (in_acc && s_axis_tuser[0] == hs_pkg::FUNC_MEASURE) begin
      run_min <= (pix_in < base_min) ? pix_in : base_min;
      run_max <= (pix_in > base_max) ? pix_in : base_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hs_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      if (out_load) begin
        done <= 1'b0;
      end
      case (state)
        hs_pkg::ST_IDLE: begin
          if (in_acc && s_axis_tuser[0] == hs_pkg::FUNC_APPLY) begin
            state <= hs_pkg::ST_MUL;
          end
        end
        hs_pkg::ST_MUL: begin
          if (run_max <= run_min || pix <= run_min) begin
            state <= hs_pkg::ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= hs_pkg::ST_CHK;
          end
        end
        hs_pkg::ST_CHK: begin
          if (num[hs_pkg::NUM_W-1:W] >= range) begin
            state <= hs_pkg::ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= hs_pkg::ST_DIV;
          end
        end
        hs_pkg::ST_DIV: begin
          if (cnt == hs_pkg::CNT_W'(W - 1)) begin
            state <= hs_pkg::ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= hs_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // datapath: multiply, overflow check, restoring divide
  always_ff @(posedge clk) begin
    case (state)
      hs_pkg::ST_IDLE: begin
        if (in_acc) begin
          pix <= pix_in;
        end
      end
      hs_pkg::ST_MUL: begin
        flat  <= (run_max <= run_min);
        range <= run_max - run_min;
        num   <= prod;
        quo   <= '0;
      end
      hs_pkg::ST_CHK: begin
        cnt <= '0;
        rem <= num[hs_pkg::NUM_W-1:W];
        // quotient of 2^16 or more always saturates
        quo <= (num[hs_pkg::NUM_W-1:W] >= range) ? max_gray : num[W-1:0];
      end
      hs_pkg::ST_DIV: begin
        cnt <= cnt + 1'b1;
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= (quo > max_gray) ? max_gray : quo;
      m_axis_tuser <= flat;
    end
  end

endmodule

// File: hw/rtl/hs_checker.sv
module hs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // flat range always forces a zero result
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("flat result not zero");

  // an apply word occupies the datapath, so the input closes next cycle
  a_apply_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == hs_pkg::FUNC_APPLY
    |=> !s_axis_tready)
    else $error("input ready right after apply word");

  // a measure word never blocks the next one
  a_measure_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == hs_pkg::FUNC_MEASURE
    |=> s_axis_tready)
    else $error("input closed after measure word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind histogram_stretch hs_checker u_hs_checker (.*);
